>>> rtl/core/grtt_pkg.sv
// Shared types, widths and codes of the grid ray tile trace unit.
`default_nettype none
package grtt_pkg;

  localparam int unsigned MAP_SIDE_DEF  = 64;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CELL_W   = 6;
  localparam int unsigned POS_W    = 22;
  localparam int unsigned DIR_W    = 23;
  localparam int unsigned BUDGET_W = 16;
  localparam int unsigned STAT_W   = 2;

  // Minor position accumulator: start position plus one step, with sign.
  localparam int unsigned MPOS_W = 34;
  // Step divider operands: |minor|*256 over |major|>>8.
  localparam int unsigned DIVD_W = DIR_W + 8;
  localparam int unsigned DIVS_W = DIR_W - 8;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRACE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

  localparam logic [STAT_W-1:0] STAT_NONE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_HIT  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OUT  = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_WR, ST_RD, ST_RD_WAIT, ST_SEEN_CLR, ST_DIV_GO, ST_DIV,
    ST_INIT, ST_STEP, ST_CHK, ST_CWAIT, ST_TWAIT, ST_DONE
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_CLR_ALL, OP_CLR_SEEN, OP_WRITE, OP_READ_RES, OP_DIV_START,
    OP_INIT, OP_SET_OUT, OP_STEP, OP_RD_CORNER, OP_RD_TILE, OP_RD_TILE_UPD,
    OP_HIT_CORNER, OP_HIT_TILE, OP_COUNT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic div_done;
    logic start_out;
    logic step_out;
    logic tile_out;
    logic min_changed;
    logic corner_hit;
    logic tile_hit;
    logic budget_done;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/grtt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module grtt_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire [WIDTH-1:0]           wdata_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/core/grtt_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module grtt_div
  import grtt_pkg::*;
#(
  parameter int unsigned NW = DIVD_W,
  parameter int unsigned DW = DIVS_W
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            start_i,
  input  wire [NW-1:0]   dividend_i,
  input  wire [DW-1:0]   divisor_i,
  output logic           done_o,
  output logic [NW-1:0]  quot_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [DW-1:0] rem_q;
  logic [NW-1:0] quo_q;
  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW:0]   rem_n;

  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, divisor_i};
  assign rem_n  = ge ? (rem_sh - {1'b0, divisor_i}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(NW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_n[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

>>> rtl/core/grtt_dp.sv
// Datapath: tile maps, trace position registers, step divider and result register.
`default_nettype none
module grtt_dp
  import grtt_pkg::*;
#(
  parameter int unsigned MAP_SIDE  = MAP_SIDE_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire dp_cmd_t               cmd_i,
  output dp_sts_t                    sts_o,
  input  wire [CELL_W-1:0]           cell_x_i,
  input  wire [CELL_W-1:0]           cell_y_i,
  input  wire                        solid_in_i,
  input  wire [POS_W-1:0]            start_x_i,
  input  wire [POS_W-1:0]            start_y_i,
  input  wire signed [DIR_W-1:0]     dir_x_i,
  input  wire signed [DIR_W-1:0]     dir_y_i,
  input  wire [BUDGET_W-1:0]         step_budget_i,
  input  wire                        out_ready_i,
  output logic                       out_valid_o,
  output logic [STAT_W-1:0]          status_o,
  output logic [CELL_W-1:0]          hit_x_o,
  output logic [CELL_W-1:0]          hit_y_o,
  output logic                       solid_out_o,
  output logic                       seen_out_o
);

  localparam int unsigned AW    = $clog2(MAP_SIDE);
  localparam int unsigned CA_W  = 2 * AW;
  localparam int unsigned DEPTH = 1 << CA_W;
  localparam int unsigned TW    = MPOS_W - FRAC_BITS;
  localparam logic signed [TW-1:0] SIDE_T = TW'(MAP_SIDE);

  function automatic logic in_rng(logic signed [TW-1:0] v);
    in_rng = (v >= 0) && (v < SIDE_T);
  endfunction

  function automatic logic [CA_W-1:0] addr_of(logic signed [TW-1:0] x,
                                              logic signed [TW-1:0] y);
    addr_of = {y[AW-1:0], x[AW-1:0]};
  endfunction

  function automatic logic signed [TW-1:0] tile_of(logic signed [MPOS_W-1:0] v);
    tile_of = TW'(v >>> FRAC_BITS);
  endfunction

  // Latched item.
  logic [CELL_W-1:0]       cx_q, cy_q;
  logic                    sol_q;
  logic [POS_W-1:0]        sx_q, sy_q;
  logic signed [DIR_W-1:0] dx_q, dy_q;
  logic [BUDGET_W-1:0]     bud_q;

  // Trace state.
  logic                     axis_y_q, inc_neg_q, corner_ok_q;
  logic signed [TW-1:0]     maj_q, min_q, prev_q, oldm_q, cnx_q, cny_q;
  logic signed [MPOS_W-1:0] mpos_q, mstep_q;
  logic [BUDGET_W-1:0]      count_q;
  logic [CA_W-1:0]          sweep_q;

  // Result and output registers.
  logic [STAT_W-1:0] res_stat_q, out_stat_q;
  logic [CELL_W-1:0] res_hx_q, res_hy_q, out_hx_q, out_hy_q;
  logic              res_sol_q, res_seen_q, out_sol_q, out_seen_q;
  logic              out_valid_q;

  // Direction decode.
  logic [DIR_W-1:0]        mag_x, mag_y, mag_a, mag_b;
  logic                    axis_y;
  logic signed [DIR_W-1:0] dir_a, dir_b;
  logic [DIVS_W-1:0]       divisor;
  logic [DIVD_W-1:0]       quot;
  logic                    div_done;
  logic signed [MPOS_W-1:0] mstep_c, qext, pos_b;

  assign mag_x  = dx_q[DIR_W-1] ? DIR_W'(-dx_q) : dx_q;
  assign mag_y  = dy_q[DIR_W-1] ? DIR_W'(-dy_q) : dy_q;
  assign axis_y = !(mag_x > mag_y);
  assign dir_a  = axis_y ? dy_q : dx_q;
  assign dir_b  = axis_y ? dx_q : dy_q;
  assign mag_a  = axis_y ? mag_y : mag_x;
  assign mag_b  = axis_y ? mag_x : mag_y;
  assign divisor = (mag_a[DIR_W-1:8] == '0) ? DIVS_W'(1) : mag_a[DIR_W-1:8];
  assign pos_b  = signed'(MPOS_W'(axis_y ? sx_q : sy_q));
  assign qext   = signed'(MPOS_W'(quot));

  always_comb begin
    if (quot == '0) begin
      mstep_c = (!dir_b[DIR_W-1] && dir_b != '0) ? MPOS_W'(1) : -MPOS_W'(1);
    end else begin
      mstep_c = dir_b[DIR_W-1] ? -qext : qext;
    end
  end

  grtt_div #(.NW(DIVD_W), .DW(DIVS_W)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.op == OP_DIV_START),
    .dividend_i({mag_b, 8'b0}),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // Coordinates.
  logic signed [TW-1:0] cxt, cyt, sxt, syt, maj_n, min_n;
  logic signed [TW-1:0] stp_x, stp_y, t_x, t_y, cmaj, cmin, c_x, c_y;
  logic signed [MPOS_W-1:0] mpos_n;
  logic                 cell_in;

  assign cxt   = signed'(TW'(cx_q));
  assign cyt   = signed'(TW'(cy_q));
  assign sxt   = signed'(TW'(sx_q >> FRAC_BITS));
  assign syt   = signed'(TW'(sy_q >> FRAC_BITS));
  assign cell_in = in_rng(cxt) && in_rng(cyt);
  assign maj_n = inc_neg_q ? (maj_q - TW'(1)) : (maj_q + TW'(1));
  assign mpos_n = mpos_q + mstep_q;
  assign min_n = tile_of(mpos_n);
  assign stp_x = axis_y_q ? min_q : maj_n;
  assign stp_y = axis_y_q ? maj_n : min_q;
  assign t_x   = axis_y_q ? min_q : maj_q;
  assign t_y   = axis_y_q ? maj_q : min_q;
  assign cmaj  = inc_neg_q ? maj_q : prev_q;
  assign cmin  = inc_neg_q ? oldm_q : min_q;
  assign c_x   = axis_y_q ? cmin : cmaj;
  assign c_y   = axis_y_q ? cmaj : cmin;

  // Map ports.
  logic            solid_we, seen_we, seen_wd, solid_wd, solid_rd, seen_rd;
  logic [CA_W-1:0] solid_wa, seen_wa, solid_ra, cell_a;

  assign cell_a = addr_of(cxt, cyt);

  always_comb begin
    solid_we = 1'b0;
    solid_wa = sweep_q;
    solid_wd = 1'b0;
    seen_we  = 1'b0;
    seen_wa  = sweep_q;
    seen_wd  = 1'b0;
    solid_ra = cell_a;
    case (cmd_i.op)
      OP_CLR_ALL: begin
        solid_we = 1'b1;
        seen_we  = 1'b1;
      end
      OP_CLR_SEEN: seen_we = 1'b1;
      OP_WRITE: begin
        solid_we = cell_in;
        solid_wa = cell_a;
        solid_wd = sol_q;
      end
      OP_INIT: begin
        seen_we = 1'b1;
        seen_wa = addr_of(sxt, syt);
        seen_wd = 1'b1;
      end
      OP_STEP: begin
        seen_we = 1'b1;
        seen_wa = addr_of(stp_x, stp_y);
        seen_wd = 1'b1;
      end
      OP_RD_CORNER: solid_ra = addr_of(c_x, c_y);
      OP_RD_TILE, OP_RD_TILE_UPD: solid_ra = addr_of(t_x, t_y);
      default: ;
    endcase
  end

  grtt_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_solid (
    .clk_i(clk_i), .we_i(solid_we), .waddr_i(solid_wa), .wdata_i(solid_wd),
    .raddr_i(solid_ra), .rdata_o(solid_rd)
  );

  grtt_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_seen (
    .clk_i(clk_i), .we_i(seen_we), .waddr_i(seen_wa), .wdata_i(seen_wd),
    .raddr_i(cell_a), .rdata_o(seen_rd)
  );

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        cx_q  <= cell_x_i;
        cy_q  <= cell_y_i;
        sol_q <= solid_in_i;
        sx_q  <= start_x_i;
        sy_q  <= start_y_i;
        dx_q  <= dir_x_i;
        dy_q  <= dir_y_i;
        bud_q <= step_budget_i;
        res_stat_q <= STAT_NONE;
        res_hx_q   <= '0;
        res_hy_q   <= '0;
        res_sol_q  <= 1'b0;
        res_seen_q <= 1'b0;
        count_q    <= '0;
      end
      OP_READ_RES: begin
        res_sol_q  <= cell_in & solid_rd;
        res_seen_q <= cell_in & seen_rd;
      end
      OP_INIT: begin
        axis_y_q  <= axis_y;
        inc_neg_q <= !(!dir_a[DIR_W-1] && dir_a != '0);
        maj_q     <= axis_y ? syt : sxt;
        min_q     <= axis_y ? sxt : syt;
        mpos_q    <= pos_b;
        mstep_q   <= mstep_c;
        oldm_q    <= tile_of(pos_b + mstep_c);
      end
      OP_SET_OUT: res_stat_q <= STAT_OUT;
      OP_STEP: begin
        prev_q <= maj_q;
        maj_q  <= maj_n;
        mpos_q <= mpos_n;
        min_q  <= min_n;
      end
      OP_RD_CORNER: begin
        cnx_q       <= c_x;
        cny_q       <= c_y;
        corner_ok_q <= in_rng(c_x) && in_rng(c_y);
      end
      OP_RD_TILE_UPD: oldm_q <= min_q;
      OP_HIT_CORNER: begin
        res_stat_q <= STAT_HIT;
        res_hx_q   <= cnx_q[CELL_W-1:0];
        res_hy_q   <= cny_q[CELL_W-1:0];
      end
      OP_HIT_TILE: begin
        res_stat_q <= STAT_HIT;
        res_hx_q   <= t_x[CELL_W-1:0];
        res_hy_q   <= t_y[CELL_W-1:0];
      end
      OP_COUNT: count_q <= count_q + BUDGET_W'(1);
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_stat_q <= res_stat_q;
      out_hx_q   <= res_hx_q;
      out_hy_q   <= res_hy_q;
      out_sol_q  <= res_sol_q;
      out_seen_q <= res_seen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_CLR_ALL || cmd_i.op == OP_CLR_SEEN) begin
        sweep_q <= sweep_q + CA_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.sweep_last  = &sweep_q;
  assign sts_o.div_done    = div_done;
  assign sts_o.start_out   = !(in_rng(sxt) && in_rng(syt));
  assign sts_o.step_out    = !in_rng(maj_n);
  assign sts_o.tile_out    = !in_rng(min_q);
  assign sts_o.min_changed = min_q != oldm_q;
  assign sts_o.corner_hit  = corner_ok_q & solid_rd;
  assign sts_o.tile_hit    = solid_rd;
  assign sts_o.budget_done = (bud_q != '0) &&
                             ({1'b0, count_q} + 17'd1 >= {1'b0, bud_q});
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_stat_q;
  assign hit_x_o     = out_hx_q;
  assign hit_y_o     = out_hy_q;
  assign solid_out_o = out_sol_q;
  assign seen_out_o  = out_seen_q;

endmodule
`default_nettype wire

>>> rtl/core/grtt_ctrl.sv
// Controller state machine that sequences the datapath for each item.
`default_nettype none
module grtt_ctrl
  import grtt_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire [MODE_W-1:0]  mode_i,
  output logic              in_ready_o,
  input  wire dp_sts_t      sts_i,
  output dp_cmd_t           cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = OP_NOP;
    cmd_o.out_load = 1'b0;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.op = OP_CLR_ALL;
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          case (mode_i)
            MODE_WRITE: state_d = ST_WR;
            MODE_TRACE: state_d = ST_DIV_GO;
            MODE_READ:  state_d = ST_RD;
            default:    state_d = ST_SEEN_CLR;
          endcase
        end
      end
      ST_WR: begin
        cmd_o.op = OP_WRITE;
        state_d  = ST_DONE;
      end
      ST_RD: state_d = ST_RD_WAIT;
      ST_RD_WAIT: begin
        cmd_o.op = OP_READ_RES;
        state_d  = ST_DONE;
      end
      ST_SEEN_CLR: begin
        cmd_o.op = OP_CLR_SEEN;
        if (sts_i.sweep_last) state_d = ST_DONE;
      end
      ST_DIV_GO: begin
        cmd_o.op = OP_DIV_START;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_INIT;
      end
      ST_INIT: begin
        if (sts_i.start_out) begin
          cmd_o.op = OP_SET_OUT;
          state_d  = ST_DONE;
        end else begin
          cmd_o.op = OP_INIT;
          state_d  = ST_STEP;
        end
      end
      ST_STEP: begin
        if (sts_i.step_out) begin
          cmd_o.op = OP_SET_OUT;
          state_d  = ST_DONE;
        end else begin
          cmd_o.op = OP_STEP;
          state_d  = ST_CHK;
        end
      end
      ST_CHK: begin
        if (sts_i.tile_out) begin
          cmd_o.op = OP_SET_OUT;
          state_d  = ST_DONE;
        end else if (sts_i.min_changed) begin
          cmd_o.op = OP_RD_CORNER;
          state_d  = ST_CWAIT;
        end else begin
          cmd_o.op = OP_RD_TILE;
          state_d  = ST_TWAIT;
        end
      end
      ST_CWAIT: begin
        if (sts_i.corner_hit) begin
          cmd_o.op = OP_HIT_CORNER;
          state_d  = ST_DONE;
        end else begin
          cmd_o.op = OP_RD_TILE_UPD;
          state_d  = ST_TWAIT;
        end
      end
      ST_TWAIT: begin
        if (sts_i.tile_hit) begin
          cmd_o.op = OP_HIT_TILE;
          state_d  = ST_DONE;
        end else if (sts_i.budget_done) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.op = OP_COUNT;
          state_d  = ST_STEP;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_cwait_from_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CWAIT) |-> ($past(state_q) == ST_CHK))
    else $error("corner wait entered without a corner read");

  a_twait_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TWAIT) |-> ($past(state_q) == ST_CHK || $past(state_q) == ST_CWAIT))
    else $error("tile wait entered without a tile read");

  a_div_to_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && sts_i.div_done) |=> (state_q == ST_INIT))
    else $error("divider result not taken");

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) |=> (state_q != ST_CLEAR))
    else $error("reset clearing pass re-entered");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result overwrites one not yet transferred");
`endif

endmodule
`default_nettype wire

>>> rtl/core/grid_ray_tile_trace_unit.sv
// Top level of the grid ray tile trace unit: stream ports, controller and datapath.
`default_nettype none
// The unit holds a MAP_SIDE x MAP_SIDE map of solid flags and one of seen marks,
// both in block RAM. Each input transfer carries one command in tuser: write a
// tile's solid flag, trace a ray, read a tile's flags, or clear all seen marks;
// every command returns exactly one result transfer. After reset the unit first
// clears both maps, one entry per cycle, and takes no input until all MAP_SIDE^2
// entries (4096 at the default size) are clear. A write stores the flag and a
// read registers both flags before the result moves to the output register. A
// seen-mark clear sweeps the seen map one entry per cycle. A trace first computes
// the minor step with a bit-serial divider, then walks tile by tile: each step
// costs one seen write and one or two solid-map reads through the single read
// port, two when the minor tile changes and the corner tile is read. Items are
// handled one at a time; a finished result sits in an output register, so the
// next item is taken while it waits for the sink.
module grid_ray_tile_trace_unit
  import grtt_pkg::*;
#(
  parameter int unsigned MAP_SIDE  = MAP_SIDE_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: cell_x, cell_y, solid_in, start_x, start_y, dir_x, dir_y,
  // step_budget, one zero pad bit.
  input  wire [119:0]  s_axis_tdata,
  // tuser: mode.
  input  wire [1:0]    s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // tdata from bit 0: hit_x, hit_y, solid_out, seen_out, two zero pad bits.
  output logic [15:0]  m_axis_tdata,
  // tuser: status.
  output logic [1:0]   m_axis_tuser
);

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [CELL_W-1:0] hit_x, hit_y;
  logic              solid_out, seen_out;

  grtt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .mode_i    (s_axis_tuser),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  grtt_dp #(.MAP_SIDE(MAP_SIDE), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cell_x_i     (s_axis_tdata[5:0]),
    .cell_y_i     (s_axis_tdata[11:6]),
    .solid_in_i   (s_axis_tdata[12]),
    .start_x_i    (s_axis_tdata[34:13]),
    .start_y_i    (s_axis_tdata[56:35]),
    .dir_x_i      (signed'(s_axis_tdata[79:57])),
    .dir_y_i      (signed'(s_axis_tdata[102:80])),
    .step_budget_i(s_axis_tdata[118:103]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .status_o     (m_axis_tuser),
    .hit_x_o      (hit_x),
    .hit_y_o      (hit_y),
    .solid_out_o  (solid_out),
    .seen_out_o   (seen_out)
  );

  assign m_axis_tdata = {2'b00, seen_out, solid_out, hit_y, hit_x};

endmodule
`default_nettype wire

>>> verif/grid_ray_tile_trace_unit_test.sv
// Self-checking stream testbench for the grid ray tile trace unit.
`timescale 1ns / 100ps
module grid_ray_tile_trace_unit_test;
  import grtt_pkg::*;

  localparam int unsigned SIDE        = 64;
  localparam int unsigned FRAC        = 16;
  localparam int unsigned N_RANDOM    = 1600;
  localparam longint      CYCLE_LIMIT = 4000000;

  // One command as the sender sees it.
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [CELL_W-1:0]        cell_x;
    logic [CELL_W-1:0]        cell_y;
    logic                     solid_in;
    logic [POS_W-1:0]         start_x;
    logic [POS_W-1:0]         start_y;
    logic signed [DIR_W-1:0]  dir_x;
    logic signed [DIR_W-1:0]  dir_y;
    logic [BUDGET_W-1:0]      step_budget;
  } cmd_t;

  // One result as the unit should return it.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CELL_W-1:0] hit_x;
    logic [CELL_W-1:0] hit_y;
    logic              solid_out;
    logic              seen_out;
  } res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  grid_ray_tile_trace_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Shadow copies of the two tile maps, updated as commands are accepted.
  bit   solid_shadow [SIDE*SIDE];
  bit   seen_shadow  [SIDE*SIDE];

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  cmd_t cur_cmd;
  int   errors = 0;
  int   accepted = 0;
  int   total_cmds = 0;
  int   n_traces = 0, n_hits = 0, n_outs = 0, n_reads = 0, n_clears = 0;
  longint cycles = 0;
  // Idle mix: 0 sender light and sink heavy, 1 the reverse, 2 no idling at all.
  int   idle_phase = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit on_map(longint x, longint y);
    return x >= 0 && y >= 0 && x < SIDE && y < SIDE;
  endfunction

  function automatic bit wall_at(longint x, longint y);
    if (!on_map(x, y)) return 1'b0;
    return solid_shadow[y*SIDE + x];
  endfunction

  // Steps the ray tile by tile along its major axis, marking tiles seen and
  // checking the corner tile whenever the minor tile changes.
  function automatic res_t cast_ray(cmd_t c);
    longint pos[2], dir[2], mag[2], t[2], k[2];
    longint mstep, mpos, oldm, dv, prevmaj;
    int a, b, inc;
    int unsigned steps;
    res_t r;
    r = '0;
    pos[0] = c.start_x;
    pos[1] = c.start_y;
    dir[0] = $signed(c.dir_x);
    dir[1] = $signed(c.dir_y);
    mag[0] = dir[0] < 0 ? -dir[0] : dir[0];
    mag[1] = dir[1] < 0 ? -dir[1] : dir[1];
    t[0] = pos[0] >>> FRAC;
    t[1] = pos[1] >>> FRAC;
    if (!on_map(t[0], t[1])) begin
      r.status = STAT_OUT;
      return r;
    end
    seen_shadow[t[1]*SIDE + t[0]] = 1'b1;
    a = (mag[0] > mag[1]) ? 0 : 1;
    b = 1 - a;
    dv = mag[a] >>> 8;
    if (dv == 0) dv = 1;
    // Signed division truncates toward zero, as the step calculation needs.
    mstep = (dir[b] * 256) / dv;
    if (mstep == 0) mstep = dir[b] > 0 ? 1 : -1;
    inc = dir[a] > 0 ? 1 : -1;
    mpos = pos[b];
    oldm = (mpos + mstep) >>> FRAC;
    steps = 0;
    forever begin
      prevmaj = t[a];
      t[a] += inc;
      if (!on_map(t[0], t[1])) begin
        r.status = STAT_OUT;
        return r;
      end
      seen_shadow[t[1]*SIDE + t[0]] = 1'b1;
      mpos += mstep;
      t[b] = mpos >>> FRAC;
      if (!on_map(t[0], t[1])) begin
        r.status = STAT_OUT;
        return r;
      end
      if (t[b] != oldm) begin
        if (inc > 0) begin
          k[a] = prevmaj;
          k[b] = t[b];
        end else begin
          k[a] = t[a];
          k[b] = oldm;
        end
        if (wall_at(k[0], k[1])) begin
          r.status = STAT_HIT;
          r.hit_x = k[0][CELL_W-1:0];
          r.hit_y = k[1][CELL_W-1:0];
          return r;
        end
        oldm = t[b];
      end
      if (wall_at(t[0], t[1])) begin
        r.status = STAT_HIT;
        r.hit_x = t[0][CELL_W-1:0];
        r.hit_y = t[1][CELL_W-1:0];
        return r;
      end
      steps++;
      if (c.step_budget != 0 && steps >= c.step_budget) return r;
    end
  endfunction

  // Applies one accepted command to the shadow maps and gives its result.
  function automatic res_t apply_cmd(cmd_t c);
    res_t r;
    r = '0;
    case (c.mode)
      MODE_WRITE: begin
        if (on_map(c.cell_x, c.cell_y)) solid_shadow[c.cell_y*SIDE + c.cell_x] = c.solid_in;
      end
      MODE_TRACE: begin
        r = cast_ray(c);
      end
      MODE_READ: begin
        if (on_map(c.cell_x, c.cell_y)) begin
          r.solid_out = solid_shadow[c.cell_y*SIDE + c.cell_x];
          r.seen_out  = seen_shadow[c.cell_y*SIDE + c.cell_x];
        end
      end
      default: begin
        foreach (seen_shadow[i]) seen_shadow[i] = 1'b0;
      end
    endcase
    return r;
  endfunction

  function automatic cmd_t mk_cmd(logic [MODE_W-1:0] m, int cx, int cy, bit s,
                                  int sx, int sy, int dx, int dy, int bud);
    cmd_t c;
    c.mode = m;
    c.cell_x = CELL_W'(cx);
    c.cell_y = CELL_W'(cy);
    c.solid_in = s;
    c.start_x = POS_W'(sx);
    c.start_y = POS_W'(sy);
    c.dir_x = DIR_W'(dx);
    c.dir_y = DIR_W'(dy);
    c.step_budget = BUDGET_W'(bud);
    return c;
  endfunction

  // A random direction component: full range, mid range, or small so the divisor can hit zero.
  function automatic int rand_dir();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 1023) - 512;
      1: v = $urandom_range(0, 20000) - 10000;
      default: v = $urandom_range(0, 23'h7FFFFF) - 23'h400000;
    endcase
    return v;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int pick;
    pick = $urandom_range(0, 199);
    c = $bits(cmd_t)'({$urandom, $urandom, $urandom, $urandom});
    if (pick < 60) begin
      c.mode = MODE_WRITE;
      // Keep the walls sparse enough that rays travel some distance.
      c.solid_in = ($urandom_range(0, 3) == 0);
    end else if (pick < 150) begin
      c.mode = MODE_TRACE;
      c.dir_x = DIR_W'(rand_dir());
      c.dir_y = DIR_W'(rand_dir());
      if ($urandom_range(0, 1)) c.step_budget = BUDGET_W'($urandom_range(0, 20));
    end else if (pick < 198) begin
      c.mode = MODE_READ;
    end else begin
      c.mode = MODE_CLEAR;
    end
    return c;
  endfunction

  // Stimulus: a directed opening, then the random body.
  initial begin
    pending_cmds.push_back(mk_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(MODE_WRITE, 63, 63, 1, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(MODE_WRITE, 0, 0, 1, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(MODE_WRITE, 10, 20, 1, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(MODE_READ, 63, 63, 0, 0, 0, 0, 0, 0));
    // Both direction components zero: the ray heads toward negative y.
    pending_cmds.push_back(mk_cmd(MODE_TRACE, 0, 0, 0, 10 << 16, 30 << 16, 0, 0, 0));
    // Ray straight into the wall at column 10, row 20 along x.
    pending_cmds.push_back(mk_cmd(MODE_TRACE, 0, 0, 0, 2 << 16, 20 << 16, 1 << 16, 0, 0));
    // Negative major direction, diagonal, reaching the corner wall.
    pending_cmds.push_back(mk_cmd(MODE_TRACE, 0, 0, 0, 5 << 16, 5 << 16,
                                  -(1 << 16), -(1 << 16), 0));
    // Tiny direction: the zero divisor is turned into one.
    pending_cmds.push_back(mk_cmd(MODE_TRACE, 0, 0, 0, 32 << 16, 32 << 16, 3, 1, 0));
    // Extreme directions and start positions.
    pending_cmds.push_back(mk_cmd(MODE_TRACE, 0, 0, 0, 22'h3FFFFF, 22'h3FFFFF,
                                  23'h3FFFFF, 23'h3FFFFF, 0));
    pending_cmds.push_back(mk_cmd(MODE_TRACE, 0, 0, 0, 0, 22'h3FFFFF,
                                  -23'sd4194304, 23'h3FFFFF, 0));
    pending_cmds.push_back(mk_cmd(MODE_TRACE, 0, 0, 0, 22'h3FFFFF, 0,
                                  23'h3FFFFF, -23'sd4194304, 16'hFFFF));
    // Budgets of one step and of a few steps end the trace with no hit.
    pending_cmds.push_back(mk_cmd(MODE_TRACE, 0, 0, 0, 40 << 16, 40 << 16, 1 << 16, 7, 1));
    pending_cmds.push_back(mk_cmd(MODE_TRACE, 0, 0, 0, 40 << 16, 40 << 16, -5, 1 << 15, 5));
    pending_cmds.push_back(mk_cmd(MODE_READ, 41, 40, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(MODE_READ, 41, 40, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(MODE_WRITE, 10, 20, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(MODE_READ, 10, 20, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < N_RANDOM; i++) pending_cmds.push_back(rand_cmd());
    total_cmds = pending_cmds.size();
  end

  // Reset, then wait for the last result and let the unit settle.
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (accepted < total_cmds || total_cmds == 0 || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Covered %0d commands: %0d traces (%0d hits, %0d off the map), %0d reads,",
             total_cmds, n_traces, n_hits, n_outs, n_reads);
    $display("and %0d seen-map clears, under three sender and sink idle mixes.", n_clears);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Sender: on each accepted transfer, predict its result and present the next command.
  always @(posedge clk_i) begin
    int idle_pct;
    res_t r;
    cycles <= cycles + 1;
    idle_phase = (accepted < total_cmds / 3) ? 0 : (accepted < 2 * total_cmds / 3) ? 1 : 2;
    idle_pct = (idle_phase == 0) ? 27 : (idle_phase == 1) ? 66 : 0;
    if (s_axis_tvalid && s_axis_tready) begin
      r = apply_cmd(cur_cmd);
      expected_results.push_back(r);
      accepted++;
      if (cur_cmd.mode == MODE_TRACE) n_traces++;
      if (cur_cmd.mode == MODE_READ) n_reads++;
      if (cur_cmd.mode == MODE_CLEAR) n_clears++;
    end
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        cur_cmd = pending_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cur_cmd.mode;
        s_axis_tdata  <= {1'b0, cur_cmd.step_budget, cur_cmd.dir_y, cur_cmd.dir_x,
                          cur_cmd.start_y, cur_cmd.start_x, cur_cmd.solid_in,
                          cur_cmd.cell_y, cur_cmd.cell_x};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink: stalls at random and checks every result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    int stall_pct;
    res_t e;
    stall_pct = (idle_phase == 0) ? 66 : (idle_phase == 1) ? 27 : 0;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no command outstanding: status %0d", m_axis_tuser);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (e.status == STAT_HIT) n_hits++;
        if (e.status == STAT_OUT) n_outs++;
        if (m_axis_tuser !== e.status) begin
          $error("status expected %0d actual %0d", e.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[5:0] !== e.hit_x) begin
          $error("hit_x expected %0d actual %0d", e.hit_x, m_axis_tdata[5:0]);
          errors++;
        end
        if (m_axis_tdata[11:6] !== e.hit_y) begin
          $error("hit_y expected %0d actual %0d", e.hit_y, m_axis_tdata[11:6]);
          errors++;
        end
        if (m_axis_tdata[12] !== e.solid_out) begin
          $error("solid_out expected %0d actual %0d", e.solid_out, m_axis_tdata[12]);
          errors++;
        end
        if (m_axis_tdata[13] !== e.seen_out) begin
          $error("seen_out expected %0d actual %0d", e.seen_out, m_axis_tdata[13]);
          errors++;
        end
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
